// ===== rtl/vbt_pkg.sv =====
// Shared types and constants for the vario beep tone controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package vbt_pkg;

  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned DivWidth    = 31;
  localparam int unsigned DivStepBits = $clog2(DivWidth);
  localparam int unsigned ScaleNum    = 100000;
  localparam int unsigned ScaleBits   = $clog2(ScaleNum + 1);
  localparam int unsigned RateMul     = 105;
  localparam int unsigned PctRecip    = 1374389535;
  localparam int unsigned PctShift    = 37;
  localparam int unsigned ShortLen    = 7;
  localparam int unsigned PeriodRecip = 205;
  localparam int unsigned PeriodShift = 11;

  localparam logic [15:0] FreqReset   = 16'd1000;
  localparam logic [7:0]  VolReset    = 8'd100;
  localparam logic [7:0]  VolMax      = 8'd100;
  localparam logic [7:0]  PeriodReset = 8'd200;

  typedef enum logic [3:0] {
    CmdTick     = 4'd0,
    CmdSetFreq  = 4'd1,
    CmdSetVol   = 4'd2,
    CmdLouder   = 4'd3,
    CmdQuieter  = 4'd4,
    CmdMute     = 4'd5,
    CmdUnmute   = 4'd6,
    CmdBeep     = 4'd7,
    CmdShort    = 4'd8,
    CmdCont     = 4'd9,
    CmdSetPer   = 4'd10
  } cmd_e;

  typedef enum logic [3:0] {
    ModeIdle  = 4'b0001,
    ModeBeep  = 4'b0010,
    ModeShort = 4'b0100,
    ModeCont  = 4'b1000
  } mode_e;

  typedef struct packed {
    logic [3:0]  command;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [23:0] pwm_reload;
    logic [23:0] pwm_compare;
    logic        tone_on;
  } out_item_t;

  typedef struct packed {
    logic [15:0] freq;
    logic [7:0]  eff_volume;
    logic        tone_on;
  } snap_t;

  typedef struct packed {
    logic                   start;
    logic [DivWidth-1:0]    dividend;
    logic [15:0]            divisor;
    logic [DivStepBits-1:0] last_step;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DivWidth-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/vbt_front.sv =====
// Front end: command decode, settings, and the beep mode machine.
// Emits one tone snapshot per tick. Depends on vbt_pkg.
`timescale 1ns / 1ps

module vbt_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  vbt_pkg::in_item_t item_i,
  output logic             snap_push_o,
  output vbt_pkg::snap_t   snap_o
);
  import vbt_pkg::*;

  logic [15:0] freq_q, freq_d;
  logic [7:0]  vol_q, vol_d;
  logic        mute_q, mute_d;
  mode_e       mode_q, mode_d;
  logic [7:0]  period_q, period_d;
  logic        gate_q, gate_d;
  logic        restart_q, restart_d;
  logic [7:0]  count_q, count_d;

  logic [7:0]  lo;
  logic [8:0]  vol_sum;
  logic [15:0] period_prod;
  logic [7:0]  period_tenth;
  logic        on;

  assign lo           = item_i.value[7:0];
  assign vol_sum      = {1'b0, vol_q} + {1'b0, lo};
  assign period_prod  = 16'(period_q) * 16'(PeriodRecip);
  assign period_tenth = 8'(period_prod >> PeriodShift);

  always_comb begin
    freq_d    = freq_q;
    vol_d     = vol_q;
    mute_d    = mute_q;
    mode_d    = mode_q;
    period_d  = period_q;
    gate_d    = gate_q;
    restart_d = restart_q;
    count_d   = count_q;
    if (accept_i) begin
      case (item_i.command)
        CmdTick: begin
          case (mode_q)
            ModeBeep: begin
              if (restart_q) begin
                restart_d = 1'b0;
                gate_d    = 1'b1;
                count_d   = '0;
              end
              count_d = 8'(count_d + 8'd1);
              if (count_d >= period_tenth) begin
                gate_d  = ~gate_d;
                count_d = '0;
              end
            end
            ModeShort: begin
              if (restart_q) begin
                restart_d = 1'b0;
                count_d   = '0;
              end
              count_d = 8'(count_d + 8'd1);
              if (count_d < 8'(ShortLen)) begin
                gate_d = 1'b0;
              end else begin
                gate_d  = 1'b1;
                count_d = '0;
              end
            end
            ModeCont: begin
              restart_d = 1'b1;
              mute_d    = 1'b0;
              gate_d    = 1'b1;
            end
            default: begin
              restart_d = 1'b1;
              gate_d    = 1'b1;
            end
          endcase
        end
        CmdSetFreq: freq_d = item_i.value;
        CmdSetVol:  vol_d = lo;
        CmdLouder: begin
          vol_d = (vol_sum <= {1'b0, VolMax}) ? vol_sum[7:0] : VolMax;
        end
        CmdQuieter: begin
          vol_d = (vol_q >= lo) ? 8'(vol_q - lo) : '0;
        end
        CmdMute:    mute_d = 1'b1;
        CmdUnmute:  mute_d = 1'b0;
        CmdBeep:    mode_d = ModeBeep;
        CmdShort:   mode_d = ModeShort;
        CmdCont:    mode_d = ModeCont;
        CmdSetPer:  period_d = lo;
        default: begin
        end
      endcase
    end
  end

  assign on          = gate_d & ~mute_d;
  assign snap_push_o = accept_i && (item_i.command == CmdTick);

  always_comb begin
    snap_o.freq       = freq_q;
    snap_o.eff_volume = on ? vol_q : '0;
    snap_o.tone_on    = on;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q    <= FreqReset;
      vol_q     <= VolReset;
      mute_q    <= 1'b0;
      mode_q    <= ModeBeep;
      period_q  <= PeriodReset;
      gate_q    <= 1'b0;
      restart_q <= 1'b1;
      count_q   <= '0;
    end else begin
      freq_q    <= freq_d;
      vol_q     <= vol_d;
      mute_q    <= mute_d;
      mode_q    <= mode_d;
      period_q  <= period_d;
      gate_q    <= gate_d;
      restart_q <= restart_d;
      count_q   <= count_d;
    end
  end

endmodule

// ===== rtl/vbt_queue.sv =====
// Short snapshot queue between front and back end.
// Depends on vbt_pkg for the snapshot type.
`timescale 1ns / 1ps

module vbt_queue #(
  parameter int unsigned Depth = vbt_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  vbt_pkg::snap_t data_i,
  input  logic           pop_i,
  output vbt_pkg::snap_t data_o,
  output logic           full_o,
  output logic           empty_o
);
  import vbt_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  snap_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_q + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_q + 1'b1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= CntW'(cnt_q + 1'b1);
      end else if (do_pop && !do_push) begin
        cnt_q <= CntW'(cnt_q - 1'b1);
      end
    end
  end

endmodule

// ===== rtl/vbt_divider.sv =====
// Restoring divider, one quotient bit per cycle, step count set per start.
// Depends on vbt_pkg for request and response types.
`timescale 1ns / 1ps

module vbt_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  vbt_pkg::div_req_t req_i,
  output vbt_pkg::div_rsp_t rsp_o
);
  import vbt_pkg::*;

  logic [15:0]            rem_q, divisor_q;
  logic [DivWidth-1:0]    dvd_q, quo_q;
  logic [DivStepBits-1:0] cnt_q;
  logic                   busy_q, done_q;
  logic [16:0]            rem_sh;
  logic                   ge;

  assign rem_sh = {rem_q, dvd_q[DivWidth-1]};
  assign ge     = (rem_sh >= {1'b0, divisor_q});

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q     <= '0;
      divisor_q <= req_i.divisor;
      dvd_q     <= req_i.dividend;
      quo_q     <= '0;
      cnt_q     <= req_i.last_step;
    end else if (busy_q) begin
      rem_q <= ge ? 16'(rem_sh - {1'b0, divisor_q}) : rem_sh[15:0];
      dvd_q <= {dvd_q[DivWidth-2:0], 1'b0};
      quo_q <= {quo_q[DivWidth-2:0], ge};
      cnt_q <= DivStepBits'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == '0) && !req_i.start;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && (cnt_q == '0)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// ===== rtl/vbt_back.sv =====
// Back end: turns a tone snapshot into PWM reload and compare values.
// Depends on vbt_pkg and vbt_divider; holds the result register.
`timescale 1ns / 1ps

module vbt_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  vbt_pkg::snap_t     q_data_i,
  output logic               q_pop_o,
  output vbt_pkg::out_item_t result_o,
  output logic               empty_o,
  input  logic               pop_i
);
  import vbt_pkg::*;

  typedef enum logic [4:0] {
    SIdle    = 5'b00001,
    SDivFreq = 5'b00010,
    SMulVol  = 5'b00100,
    SMulPct  = 5'b01000,
    SFinish  = 5'b10000
  } state_e;

  state_e      state_q, state_d;
  snap_t       snap_q;
  logic [23:0] reload_q;
  logic [30:0] prod_q;
  logic [23:0] compare_q;
  out_item_t   out_q;
  logic        out_valid_q;
  div_req_t    div_req;
  div_rsp_t    div_rsp;
  logic        take, zero_freq, out_load;
  logic [61:0] pct_prod;

  vbt_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign take      = (state_q == SIdle) && !q_empty_i;
  assign zero_freq = (q_data_i.freq == '0);
  assign q_pop_o   = take;
  assign out_load  = (state_q == SFinish) && (!out_valid_q || pop_i);
  assign pct_prod  = 62'(prod_q) * 62'(PctRecip);

  always_comb begin
    div_req = '0;
    if (take && !zero_freq) begin
      div_req.start     = 1'b1;
      div_req.dividend  = DivWidth'(ScaleNum) << (DivWidth - ScaleBits);
      div_req.divisor   = q_data_i.freq;
      div_req.last_step = DivStepBits'(ScaleBits - 1);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle: begin
        if (take) begin
          state_d = zero_freq ? SFinish : SDivFreq;
        end
      end
      SDivFreq: begin
        if (div_rsp.done) begin
          state_d = SMulVol;
        end
      end
      SMulVol: state_d = SMulPct;
      SMulPct: state_d = SFinish;
      SFinish: begin
        if (out_load) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      snap_q    <= q_data_i;
      reload_q  <= '0;
      compare_q <= '0;
    end
    if ((state_q == SDivFreq) && div_rsp.done) begin
      reload_q <= 24'(div_rsp.quotient[ScaleBits-1:0] * 7'(RateMul));
    end
    if (state_q == SMulVol) begin
      prod_q <= 31'(reload_q[23:1] * snap_q.eff_volume);
    end
    if (state_q == SMulPct) begin
      compare_q <= pct_prod[PctShift+23:PctShift];
    end
    if (out_load) begin
      out_q.pwm_reload  <= reload_q;
      out_q.pwm_compare <= compare_q;
      out_q.tone_on     <= snap_q.tone_on;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign result_o = out_q;
  assign empty_o  = !out_valid_q;

endmodule

// ===== rtl/vario_beep_tone_controller_unit.sv =====
// Vario beep tone controller: commands update the settings registers as they are accepted; a
// tick's PWM result passes the queue, 17 divider steps for the reload, volume and percent
// multiply stages and the result register (a zero frequency skips straight to the result).
// Ticks are taken back to back until the snapshot queue fills; the back end takes a new
// snapshot only after loading the last result. Reset: asynchronous, active low; settings
// return to their defaults, queue and result register empty.
`timescale 1ns / 1ps

module vario_beep_tone_controller_unit #(
  parameter int unsigned QueueDepth = vbt_pkg::QueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  vbt_pkg::in_item_t   item_i,
  output logic                empty,
  input  logic                pop,
  output vbt_pkg::out_item_t  result_o
);
  import vbt_pkg::*;

  logic  accept;
  logic  snap_push;
  snap_t snap_in, snap_out;
  logic  q_full, q_empty, q_pop;

  assign full   = q_full;
  assign accept = push && !q_full;

  vbt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (item_i),
    .snap_push_o (snap_push),
    .snap_o      (snap_in)
  );

  vbt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (snap_push),
    .data_i  (snap_in),
    .pop_i   (q_pop),
    .data_o  (snap_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  vbt_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (snap_out),
    .q_pop_o   (q_pop),
    .result_o  (result_o),
    .empty_o   (empty),
    .pop_i     (pop)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

// Self-checking testbench for vario_beep_tone_controller_unit: command and tick transfers in,
// predicted PWM reload/compare/tone_on per tick compared in order against the result queue.
// Depends on rtl/vbt_pkg.sv and rtl/vario_beep_tone_controller_unit.sv.

module tb_top;
  import vbt_pkg::*;

  localparam int unsigned ToneScale  = 100000;
  localparam int unsigned ReloadMul  = 105;
  localparam int unsigned Percent    = 100;
  localparam int unsigned ShortTicks = 7;
  localparam int unsigned PeriodDiv  = 10;
  localparam logic [7:0]  VolCeil    = 8'd100;

  localparam logic [3:0] CmdUnusedMin = 4'd11;
  localparam logic [3:0] CmdUnusedMax = 4'd15;

  localparam int RandPerPhase = 300;
  localparam int BurstTicks   = 16;
  localparam int HoldCycles   = 600;
  localparam int DrainCycles  = 120;
  localparam int IdleLimit    = 4000;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [15:0] val;
    logic        typed;
    out_item_t   res;
  } dir_row_t;

  localparam int NumDir = 27;
  localparam dir_row_t DirRows [NumDir] = '{
    '{CmdTick,      16'h0000, 1'b1, '{24'd10500,    24'd5250,     1'b1}},
    '{CmdSetFreq,   16'h0000, 1'b0, '0},
    '{CmdTick,      16'h0000, 1'b1, '{24'd0,        24'd0,        1'b1}},
    '{CmdSetFreq,   16'h0001, 1'b0, '0},
    '{CmdTick,      16'hFFFF, 1'b1, '{24'd10500000, 24'd5250000,  1'b1}},
    '{CmdSetVol,    16'hFFFF, 1'b0, '0},
    '{CmdTick,      16'h0000, 1'b1, '{24'd10500000, 24'd13387500, 1'b1}},
    '{CmdLouder,    16'h0001, 1'b0, '0},
    '{CmdQuieter,   16'hFF00, 1'b0, '0},
    '{CmdQuieter,   16'h00FF, 1'b0, '0},
    '{CmdLouder,    16'h0064, 1'b0, '0},
    '{CmdMute,      16'h0000, 1'b0, '0},
    '{CmdTick,      16'h0000, 1'b1, '{24'd10500000, 24'd0,        1'b0}},
    '{CmdUnmute,    16'hFFFF, 1'b0, '0},
    '{CmdSetFreq,   16'hFFFF, 1'b0, '0},
    '{CmdSetPer,    16'h0005, 1'b0, '0},
    '{CmdTick,      16'h0000, 1'b0, '0},
    '{CmdTick,      16'h0000, 1'b0, '0},
    '{CmdShort,     16'hAAAA, 1'b0, '0},
    '{CmdTick,      16'h0000, 1'b0, '0},
    '{CmdCont,      16'h5555, 1'b0, '0},
    '{CmdMute,      16'h0000, 1'b0, '0},
    '{CmdTick,      16'h0000, 1'b0, '0},
    '{CmdUnusedMax, 16'hFFFF, 1'b0, '0},
    '{CmdBeep,      16'h0000, 1'b0, '0},
    '{CmdSetPer,    16'h12FF, 1'b0, '0},
    '{CmdTick,      16'h0000, 1'b0, '0}
  };

  localparam int TxPct [3] = '{12, 48, 0};
  localparam int RxPct [3] = '{48, 12, 0};

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push   = 1'b0;
  logic      pop    = 1'b0;
  in_item_t  item_d = '0;
  logic      full;
  logic      empty;
  out_item_t result_o;

  // tone state mirror
  logic [15:0] p_freq    = FreqReset;
  logic [7:0]  p_vol     = VolReset;
  logic        p_muted   = 1'b0;
  mode_e       p_mode    = ModeBeep;
  logic [7:0]  p_period  = PeriodReset;
  logic        p_gate    = 1'b0;
  logic        p_restart = 1'b1;
  logic [7:0]  p_count   = 8'd0;

  out_item_t tone_results_q [$];

  int tx_idle_pct  = 12;
  int rx_idle_pct  = 48;
  int hold_req     = 0;
  int hold_done    = 0;
  int mismatch_cnt = 0;
  int checked_cnt  = 0;
  int dir_cnt      = 0;
  int rand_cnt     = 0;
  int stall_cycles = 0;

  vario_beep_tone_controller_unit uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item_d),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit tone_model_step(input in_item_t it, output out_item_t res);
    logic [7:0]  lo;
    logic [7:0]  thr;
    logic        on;
    int unsigned eff;
    int unsigned reload;
    int unsigned compare;
    lo  = it.value[7:0];
    res = '0;
    case (it.command)
      CmdTick: begin
        if (p_mode != ModeBeep && p_mode != ModeShort) p_gate = 1'b1;
        case (p_mode)
          ModeBeep: begin
            if (p_restart) begin
              p_restart = 1'b0;
              p_gate    = 1'b1;
              p_count   = 8'd0;
            end
            p_count = p_count + 8'd1;
            thr     = 8'(p_period / PeriodDiv);
            if (p_count >= thr) begin
              p_gate  = ~p_gate;
              p_count = 8'd0;
            end
          end
          ModeShort: begin
            if (p_restart) begin
              p_restart = 1'b0;
              p_gate    = 1'b1;
              p_count   = 8'd0;
            end
            p_count = p_count + 8'd1;
            if (p_count < ShortTicks) begin
              p_gate = 1'b0;
            end else begin
              p_gate  = 1'b1;
              p_count = 8'd0;
            end
          end
          ModeCont: begin
            p_restart = 1'b1;
            p_muted   = 1'b0;
            p_gate    = 1'b1;
          end
          default: p_restart = 1'b1;
        endcase
        on      = p_gate & ~p_muted;
        eff     = on ? p_vol : 0;
        reload  = 0;
        compare = 0;
        if (p_freq != 16'd0) begin
          reload  = (ToneScale / p_freq) * ReloadMul;
          compare = (reload / 2) * eff / Percent;
        end
        res.pwm_reload  = reload[23:0];
        res.pwm_compare = compare[23:0];
        res.tone_on     = on;
        return 1'b1;
      end
      CmdSetFreq: p_freq = it.value;
      CmdSetVol:  p_vol = lo;
      CmdLouder: begin
        if (int'(p_vol) + int'(lo) <= int'(VolCeil)) p_vol = p_vol + lo;
        else p_vol = VolCeil;
      end
      CmdQuieter: begin
        if (p_vol >= lo) p_vol = p_vol - lo;
        else p_vol = 8'd0;
      end
      CmdMute:   p_muted = 1'b1;
      CmdUnmute: p_muted = 1'b0;
      CmdBeep:   p_mode = ModeBeep;
      CmdShort:  p_mode = ModeShort;
      CmdCont:   p_mode = ModeCont;
      CmdSetPer: p_period = lo;
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic in_item_t rand_item();
    in_item_t    it;
    int unsigned r;
    r        = $urandom_range(0, 99);
    it.value = 16'($urandom);
    if (r < 40) begin
      it.command = CmdTick;
    end else if (r < 48) begin
      it.command = CmdSetFreq;
      case ($urandom_range(0, 3))
        0: it.value = 16'($urandom_range(0, 2));
        1: it.value = 16'($urandom_range(3, 5000));
        default: ;
      endcase
    end else if (r < 54) begin
      it.command = CmdSetVol;
      if ($urandom_range(0, 3) != 0) it.value[7:0] = 8'($urandom_range(0, 100));
    end else if (r < 60) begin
      it.command = CmdLouder;
      if ($urandom_range(0, 3) != 0) it.value[7:0] = 8'($urandom_range(0, 40));
    end else if (r < 66) begin
      it.command = CmdQuieter;
      if ($urandom_range(0, 3) != 0) it.value[7:0] = 8'($urandom_range(0, 40));
    end else if (r < 71) begin
      it.command = CmdMute;
    end else if (r < 76) begin
      it.command = CmdUnmute;
    end else if (r < 81) begin
      it.command = CmdBeep;
    end else if (r < 85) begin
      it.command = CmdShort;
    end else if (r < 88) begin
      it.command = CmdCont;
    end else if (r < 96) begin
      it.command = CmdSetPer;
      if ($urandom_range(0, 1) != 0) it.value[7:0] = 8'($urandom_range(0, 50));
    end else begin
      it.command = 4'($urandom_range(CmdUnusedMin, CmdUnusedMax));
    end
    return it;
  endfunction

  task automatic offer(input in_item_t it, input logic typed, input out_item_t typed_res);
    out_item_t res;
    bit        has_res;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push   <= 1'b1;
    item_d <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    has_res = tone_model_step(it, res);
    if (has_res) tone_results_q.push_back(typed ? typed_res : res);
  endtask

  // result side: random pop, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_done) begin
        pop <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done++;
      end else begin
        pop <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t exp_res;
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= IdleLimit) begin
        $error("no transfer for %0d cycles, %0d results pending",
               stall_cycles, tone_results_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      if (pop && !empty) begin
        if (tone_results_q.size() == 0) begin
          $error("unexpected result: pwm_reload %0d pwm_compare %0d tone_on %0b",
                 result_o.pwm_reload, result_o.pwm_compare, result_o.tone_on);
          mismatch_cnt++;
        end else begin
          exp_res = tone_results_q.pop_front();
          checked_cnt++;
          if (result_o.pwm_reload !== exp_res.pwm_reload) begin
            $error("pwm_reload: expected %0d, actual %0d",
                   exp_res.pwm_reload, result_o.pwm_reload);
            mismatch_cnt++;
          end
          if (result_o.pwm_compare !== exp_res.pwm_compare) begin
            $error("pwm_compare: expected %0d, actual %0d",
                   exp_res.pwm_compare, result_o.pwm_compare);
            mismatch_cnt++;
          end
          if (result_o.tone_on !== exp_res.tone_on) begin
            $error("tone_on: expected %0b, actual %0b", exp_res.tone_on, result_o.tone_on);
            mismatch_cnt++;
          end
        end
      end
    end
  end

  initial begin
    in_item_t it;
    int       n;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = TxPct[0];
    rx_idle_pct = RxPct[0];
    for (int i = 0; i < NumDir; i++) begin
      it.command = DirRows[i].cmd;
      it.value   = DirRows[i].val;
      offer(it, DirRows[i].typed, DirRows[i].res);
      dir_cnt++;
    end

    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct = TxPct[ph];
      rx_idle_pct = RxPct[ph];
      if (ph == 2) begin
        // drain, then fill the block against a held result side
        push <= 1'b0;
        @(posedge clk_i);
        while (tone_results_q.size() != 0) @(posedge clk_i);
        hold_req++;
        it.command = CmdTick;
        for (int k = 0; k < BurstTicks; k++) begin
          it.value = 16'($urandom);
          offer(it, 1'b0, '0);
          dir_cnt++;
        end
      end
      n = 0;
      while (n < RandPerPhase) begin
        it = rand_item();
        offer(it, 1'b0, '0);
        if (it.command <= CmdSetPer) n++;
        rand_cnt++;
      end
    end

    push <= 1'b0;
    while (tone_results_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run: %0d directed and %0d random transfers in, %0d tone results checked",
             dir_cnt, rand_cnt, checked_cnt);
    $display("Exercised all modes, mute, volume limits, period edges and extreme frequencies");
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/vbt_pkg.sv
rtl/vbt_front.sv
rtl/vbt_queue.sv
rtl/vbt_divider.sv
rtl/vbt_back.sv
rtl/vario_beep_tone_controller_unit.sv
verif/tb_top.sv
